### rtl/olie_pkg.sv
`default_nettype none
package olie_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_ERASE = 3'd2;
  localparam logic [2:0] CMD_POP = 3'd3;
  localparam logic [2:0] CMD_READ = 3'd4;
  localparam logic [2:0] CMD_RESIZE = 3'd5;
  localparam logic [2:0] CMD_CLEAR = 3'd6;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
    logic [8:0]  index;
    logic [8:0]  last_index;
    logic [8:0]  count;
  } olie_cmd_t;

  typedef struct packed {
    logic [31:0] data;
    logic [8:0]  fill;
    logic        empty_res;
    logic [1:0]  status;
  } olie_res_t;

endpackage
`default_nettype wire

### rtl/olie_ram.sv
`default_nettype none
module olie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### rtl/olie_seq.sv
`default_nettype none
module olie_seq #(
  parameter int DEPTH = olie_pkg::DEPTH_DEF,
  parameter int WORD_BITS = olie_pkg::WORD_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire olie_pkg::olie_cmd_t cmd_in,
  output logic                     idle,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output olie_pkg::olie_res_t      res
);
  import olie_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int W = (CW > 10 ? CW : 10) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RD_WAIT, S_MOVE, S_DRAIN, S_FILL, S_DONE
  } state_t;

  state_t state;
  logic [W-1:0] cnt;
  logic [W-1:0] src;
  logic [W-1:0] stop;
  logic [W-1:0] amt;
  logic         move_up;
  logic         then_fill;
  logic [W-1:0] fptr;
  logic [W-1:0] fend;
  logic [WORD_BITS-1:0] val;
  logic         pend;
  logic [W-1:0] pend_addr;
  logic [31:0]  data;
  logic [1:0]   status;

  logic [W-1:0] idx_e, last_e, cnt_e, dep_e;
  logic         wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [WORD_BITS-1:0] wr_data, rd_data;

  assign idx_e = W'(cmd_in.index);
  assign last_e = W'(cmd_in.last_index);
  assign cnt_e = W'(cmd_in.count);
  assign dep_e = W'(DEPTH);

  // Only one source drives the write port in any state.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = pend_addr[AW-1:0];
    wr_data = rd_data;
    if (pend) begin
      wr_en = 1'b1;
    end else if (state == S_FILL) begin
      wr_en = 1'b1;
      wr_addr = fptr[AW-1:0];
      wr_data = val;
    end else if (state == S_IDLE && start && cmd_in.cmd == CMD_PUSH && cnt < dep_e) begin
      wr_en = 1'b1;
      wr_addr = cnt[AW-1:0];
      wr_data = WORD_BITS'(cmd_in.value);
    end
    if (state == S_MOVE) begin
      rd_addr = src[AW-1:0];
    end else if (cmd_in.cmd == CMD_POP) begin
      rd_addr = AW'(cnt - W'(1));
    end else begin
      rd_addr = idx_e[AW-1:0];
    end
  end

  olie_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      pend <= 1'b0;
    end else begin
      pend <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            data <= '0;
            status <= ST_OK;
            val <= WORD_BITS'(cmd_in.value);
            state <= S_DONE;
            case (cmd_in.cmd)
              CMD_PUSH: begin
                if (cnt >= dep_e) status <= ST_OVF;
                else cnt <= cnt + W'(1);
              end
              CMD_INSERT: begin
                if (idx_e > cnt) begin
                  status <= ST_BAD;
                end else if (cnt + cnt_e > dep_e) begin
                  status <= ST_OVF;
                end else if (cnt_e != '0) begin
                  cnt <= cnt + cnt_e;
                  fptr <= idx_e;
                  fend <= idx_e + cnt_e;
                  then_fill <= 1'b1;
                  move_up <= 1'b0;
                  amt <= cnt_e;
                  src <= cnt - W'(1);
                  stop <= idx_e;
                  state <= (cnt > idx_e) ? S_MOVE : S_FILL;
                end
              end
              CMD_ERASE: begin
                if (idx_e > last_e || last_e > cnt) begin
                  status <= ST_BAD;
                end else if (last_e > idx_e) begin
                  cnt <= cnt - (last_e - idx_e);
                  then_fill <= 1'b0;
                  move_up <= 1'b1;
                  amt <= last_e - idx_e;
                  src <= last_e;
                  stop <= cnt - W'(1);
                  if (last_e < cnt) state <= S_MOVE;
                end
              end
              CMD_POP: begin
                if (cnt == '0) begin
                  status <= ST_EMPTY;
                end else begin
                  cnt <= cnt - W'(1);
                  state <= S_RD_WAIT;
                end
              end
              CMD_READ: begin
                if (idx_e >= cnt) status <= ST_BAD;
                else state <= S_RD_WAIT;
              end
              CMD_RESIZE: begin
                if (cnt_e > dep_e) begin
                  status <= ST_OVF;
                end else begin
                  cnt <= cnt_e;
                  if (cnt_e > cnt) begin
                    fptr <= cnt;
                    fend <= cnt_e;
                    state <= S_FILL;
                  end
                end
              end
              CMD_CLEAR: begin
                // Slots at or above the count are never read, so no sweep.
                cnt <= '0;
              end
              default: status <= ST_BAD;
            endcase
          end
        end
        S_RD_WAIT: begin
          data <= 32'(rd_data);
          state <= S_DONE;
        end
        S_MOVE: begin
          pend <= 1'b1;
          pend_addr <= move_up ? src - amt : src + amt;
          if (src == stop) begin
            state <= S_DRAIN;
          end else begin
            src <= move_up ? src + W'(1) : src - W'(1);
          end
        end
        S_DRAIN: begin
          state <= then_fill ? S_FILL : S_DONE;
        end
        S_FILL: begin
          fptr <= fptr + W'(1);
          if (fptr + W'(1) == fend) state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.data = data;
  assign res.fill = cnt[8:0];
  assign res.empty_res = (cnt == '0);
  assign res.status = status;

endmodule
`default_nettype wire

### rtl/ordered_list_insert_erase_core.sv
// Ordered list of data words with a fill count, held in one RAM.
// Input channel s_*: one command word per handshake; s_tdata carries cmd,
// value, index, last_index and count. Output channel m_*: one result word
// per command with data, fill, empty_res and status.
// Each command is worked by a sequencer over the single-port-write RAM:
// push, clear and status-only commands go straight to the result register,
// read and pop wait for the registered RAM read first. Insert and erase move
// one word per cycle through the RAM, and insert then writes its copies of
// value one per cycle; resize that grows writes one fill word per cycle.
// s_tready is high only while the sequencer is idle; one command is worked
// at a time. The result waits in an output register, so the next command is
// taken while the result is still held. If m_tready stays low the sequencer
// holds its finished result and takes nothing new.
// Reset (rst, synchronous) empties the list and drops any held result.
`default_nettype none
module ordered_list_insert_erase_core #(
  parameter int DEPTH = olie_pkg::DEPTH_DEF,
  parameter int WORD_BITS = olie_pkg::WORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // cmd[2:0], value[34:3], index[43:35], last_index[52:44], count[61:53]
  input  wire logic [63:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // data[31:0], fill[40:32], empty_res[41], status[43:42]
  output logic [47:0]      m_tdata
);
  import olie_pkg::*;

  olie_cmd_t cmd_in;
  olie_res_t res, res_q;
  logic idle, res_valid, res_ready;

  assign cmd_in.cmd = s_tdata[2:0];
  assign cmd_in.value = s_tdata[34:3];
  assign cmd_in.index = s_tdata[43:35];
  assign cmd_in.last_index = s_tdata[52:44];
  assign cmd_in.count = s_tdata[61:53];

  assign s_tready = idle;
  assign res_ready = !m_tvalid || m_tready;

  olie_seq #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (s_tvalid && idle),
    .cmd_in   (cmd_in),
    .idle     (idle),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
      if (res_valid) res_q <= res;
    end
  end

  assign m_tdata = {4'b0, res_q.status, res_q.empty_res, res_q.fill, res_q.data};

endmodule
`default_nettype wire
